// ===== design/mdet_pkg.sv =====
// Package for the most-recently-used entry table.
// Holds the entry and payload types, the control codes and the controller interface structs.
// No dependencies.
package mdet_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_READ     = 2'd3
  } action_e;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [7:0]  kind;
    logic [31:0] pos_a;
    logic [31:0] pos_b;
    logic [31:0] pos_c;
    logic [31:0] created;
  } entry_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [7:0]  kind;
    logic [31:0] pos_a;
    logic [31:0] pos_b;
    logic [31:0] pos_c;
    logic [31:0] created_time;
    logic [5:0]  slot;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] out_id_high;
    logic [63:0] out_id_low;
    logic [7:0]  out_kind;
    logic [31:0] out_pos_a;
    logic [31:0] out_pos_b;
    logic [31:0] out_pos_c;
    logic [31:0] out_created;
    logic [6:0]  fill;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHU_CHK,
    ST_SHU_WR,
    ST_WR_HEAD,
    ST_DN_CHK,
    ST_DN_WR,
    ST_RD_ADDR,
    ST_RD_CAP,
    ST_RESP
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_SLOT,
    IDX_LAST
  } idx_op_e;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_DN,
    RA_IDX_UP
  } raddr_e;

  typedef struct packed {
    logic    req_load;
    idx_op_e idx_op;
    logic    mem_rd;
    raddr_e  ra_sel;
    logic    mem_wr;
    logic    wd_req;
    logic    hit_set;
    logic    ok_set;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_capture;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    cnt_zero;
    logic    match;
    logic    search_end;
    logic    slot_ok;
    logic    idx_zero;
    logic    up_more;
  } status_t;

endpackage

// ===== design/mru_dedup_entry_table.sv =====
// Top level of the most-recently-used entry table with duplicate removal.
// Instantiates mdet_ctrl and mdet_datapath; depends on mdet_pkg.
//
// The table holds up to 64 entries in a single-port-write, registered-read memory,
// newest at slot 0, and handles one transaction at a time. Every step goes through
// that one memory port, so the time per transaction depends on the table fill: an
// add searches for a duplicate and then shifts the newer entries back by one slot;
// a contains searches; a remove at slot s moves the later entries forward; a read
// fetches one slot; an out-of-range remove or read skips the memory. A new
// transaction is taken while the previous result still waits in the output register.
module mru_dedup_entry_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mdet_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mdet_pkg::out_t out_data_o
);

  mdet_pkg::cmd_t    cmd;
  mdet_pkg::status_t sts;

  mdet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mdet_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== design/mdet_ctrl.sv =====
// Controller state machine for the entry table.
// Sequences search, shift, write and read steps; depends on mdet_pkg.
module mdet_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mdet_pkg::status_t sts_i,
  output mdet_pkg::cmd_t    cmd_o
);

  mdet_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == mdet_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdet_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mdet_pkg::ST_DISPATCH;
      end
      mdet_pkg::ST_DISPATCH: begin
        unique case (sts_i.action)
          mdet_pkg::ACT_ADD:
            state_d = sts_i.cnt_zero ? mdet_pkg::ST_SHU_CHK : mdet_pkg::ST_SRCH_RD;
          mdet_pkg::ACT_CONTAINS:
            state_d = sts_i.cnt_zero ? mdet_pkg::ST_RESP : mdet_pkg::ST_SRCH_RD;
          mdet_pkg::ACT_REMOVE:
            state_d = sts_i.slot_ok ? mdet_pkg::ST_DN_CHK : mdet_pkg::ST_RESP;
          default:
            state_d = sts_i.slot_ok ? mdet_pkg::ST_RD_ADDR : mdet_pkg::ST_RESP;
        endcase
      end
      mdet_pkg::ST_SRCH_RD: state_d = mdet_pkg::ST_SRCH_CMP;
      mdet_pkg::ST_SRCH_CMP: begin
        if (sts_i.match || sts_i.search_end) begin
          state_d = (sts_i.action == mdet_pkg::ACT_ADD) ? mdet_pkg::ST_SHU_CHK
                                                         : mdet_pkg::ST_RESP;
        end else begin
          state_d = mdet_pkg::ST_SRCH_RD;
        end
      end
      mdet_pkg::ST_SHU_CHK:
        state_d = sts_i.idx_zero ? mdet_pkg::ST_WR_HEAD : mdet_pkg::ST_SHU_WR;
      mdet_pkg::ST_SHU_WR: state_d = mdet_pkg::ST_SHU_CHK;
      mdet_pkg::ST_WR_HEAD: state_d = mdet_pkg::ST_RESP;
      mdet_pkg::ST_DN_CHK:
        state_d = sts_i.up_more ? mdet_pkg::ST_DN_WR : mdet_pkg::ST_RESP;
      mdet_pkg::ST_DN_WR: state_d = mdet_pkg::ST_DN_CHK;
      mdet_pkg::ST_RD_ADDR: state_d = mdet_pkg::ST_RD_CAP;
      mdet_pkg::ST_RD_CAP: state_d = mdet_pkg::ST_RESP;
      mdet_pkg::ST_RESP: begin
        if (out_free) state_d = mdet_pkg::ST_IDLE;
      end
      default: state_d = mdet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.idx_op = mdet_pkg::IDX_HOLD;
    cmd_o.ra_sel = mdet_pkg::RA_IDX;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      mdet_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          cmd_o.idx_op = mdet_pkg::IDX_ZERO;
        end
      end
      mdet_pkg::ST_DISPATCH: begin
        unique case (sts_i.action)
          mdet_pkg::ACT_ADD: begin
            if (sts_i.cnt_zero) cmd_o.idx_op = mdet_pkg::IDX_LAST;
          end
          mdet_pkg::ACT_CONTAINS: ;
          default: begin
            if (sts_i.slot_ok) begin
              cmd_o.idx_op = mdet_pkg::IDX_SLOT;
              cmd_o.ok_set = 1'b1;
            end
          end
        endcase
      end
      mdet_pkg::ST_SRCH_RD: cmd_o.mem_rd = 1'b1;
      mdet_pkg::ST_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.hit_set = 1'b1;
          if (sts_i.action != mdet_pkg::ACT_ADD) cmd_o.ok_set = 1'b1;
        end else if (sts_i.search_end) begin
          if (sts_i.action == mdet_pkg::ACT_ADD) cmd_o.idx_op = mdet_pkg::IDX_LAST;
        end else begin
          cmd_o.idx_op = mdet_pkg::IDX_INC;
        end
      end
      mdet_pkg::ST_SHU_CHK: begin
        if (!sts_i.idx_zero) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.ra_sel = mdet_pkg::RA_IDX_DN;
        end
      end
      mdet_pkg::ST_SHU_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.idx_op = mdet_pkg::IDX_DEC;
      end
      mdet_pkg::ST_WR_HEAD: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.wd_req = 1'b1;
        cmd_o.ok_set = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      mdet_pkg::ST_DN_CHK: begin
        if (sts_i.up_more) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.ra_sel = mdet_pkg::RA_IDX_UP;
        end else begin
          cmd_o.cnt_dec = 1'b1;
        end
      end
      mdet_pkg::ST_DN_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.idx_op = mdet_pkg::IDX_INC;
      end
      mdet_pkg::ST_RD_ADDR: cmd_o.mem_rd = 1'b1;
      mdet_pkg::ST_RD_CAP: cmd_o.rd_capture = 1'b1;
      mdet_pkg::ST_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdet_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/mdet_datapath.sv =====
// Datapath for the entry table: entry memory, index, count and result registers.
// Driven by mdet_ctrl commands; depends on mdet_pkg.
module mdet_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdet_pkg::in_t     in_data_i,
  input  mdet_pkg::cmd_t    cmd_i,
  output mdet_pkg::status_t sts_o,
  output mdet_pkg::out_t    out_data_o
);

  localparam int unsigned IdxW = mdet_pkg::IdxW;
  localparam int unsigned CntW = mdet_pkg::CntW;

  mdet_pkg::entry_t mem_q [mdet_pkg::MaxEntries];
  mdet_pkg::entry_t rd_q;
  mdet_pkg::entry_t cap_q;
  mdet_pkg::entry_t req_entry;
  mdet_pkg::in_t    req_q;
  mdet_pkg::out_t   out_q;
  logic [IdxW-1:0]  idx_q, idx_d, raddr, last_idx;
  logic [CntW-1:0]  cnt_q, cnt_d, idx_p1;
  logic             hit_q, ok_q, cnt_full;

  assign req_entry = '{id_high: req_q.id_high, id_low: req_q.id_low, kind: req_q.kind,
                       pos_a: req_q.pos_a, pos_b: req_q.pos_b, pos_c: req_q.pos_c,
                       created: req_q.created_time};

  assign idx_p1   = CntW'(idx_q) + CntW'(1);
  assign cnt_full = (cnt_q == CntW'(mdet_pkg::MaxEntries));
  assign last_idx = cnt_full ? IdxW'(mdet_pkg::MaxEntries - 1) : cnt_q[IdxW-1:0];

  assign sts_o.action     = mdet_pkg::action_e'(req_q.action);
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.match      = (rd_q.id_high == req_q.id_high) && (rd_q.id_low == req_q.id_low) &&
                            (rd_q.kind == req_q.kind) && (rd_q.pos_a == req_q.pos_a) &&
                            (rd_q.pos_b == req_q.pos_b) && (rd_q.pos_c == req_q.pos_c);
  assign sts_o.search_end = (idx_p1 >= cnt_q);
  assign sts_o.slot_ok    = (CntW'(req_q.slot) < cnt_q) &&
                            (int'(req_q.slot) < int'(mdet_pkg::MaxEntries));
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.up_more    = (idx_p1 < cnt_q);

  always_comb begin
    case (cmd_i.ra_sel)
      mdet_pkg::RA_IDX_DN: raddr = idx_q - IdxW'(1);
      mdet_pkg::RA_IDX_UP: raddr = idx_q + IdxW'(1);
      default:             raddr = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.idx_op)
      mdet_pkg::IDX_ZERO: idx_d = '0;
      mdet_pkg::IDX_INC:  idx_d = idx_q + IdxW'(1);
      mdet_pkg::IDX_DEC:  idx_d = idx_q - IdxW'(1);
      mdet_pkg::IDX_SLOT: idx_d = IdxW'(req_q.slot);
      mdet_pkg::IDX_LAST: idx_d = last_idx;
      default:            idx_d = idx_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc && !hit_q && !cnt_full) cnt_d = cnt_q + CntW'(1);
    if (cmd_i.cnt_dec) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) mem_q[idx_q] <= cmd_i.wd_req ? req_entry : rd_q;
    if (cmd_i.mem_rd) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q <= in_data_i;
      cap_q <= '0;
    end else if (cmd_i.rd_capture) begin
      cap_q <= rd_q;
    end
    if (cmd_i.out_load) begin
      out_q <= '{ok: ok_q, out_id_high: cap_q.id_high, out_id_low: cap_q.id_low,
                 out_kind: cap_q.kind, out_pos_a: cap_q.pos_a, out_pos_b: cap_q.pos_b,
                 out_pos_c: cap_q.pos_c, out_created: cap_q.created, fill: 7'(cnt_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      hit_q <= 1'b0;
      ok_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      if (cmd_i.req_load) begin
        hit_q <= 1'b0;
        ok_q  <= 1'b0;
      end else begin
        if (cmd_i.hit_set) hit_q <= 1'b1;
        if (cmd_i.ok_set) ok_q <= 1'b1;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/mdet_checker.sv =====
// Port-level checker for mru_dedup_entry_table, bound to the top level.
// Depends on mdet_pkg.
module mdet_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input mdet_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result changed while stalled.");

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fill <= 7'(mdet_pkg::MaxEntries))
    else $error("Fill exceeds table size.");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.out_id_high == '0 &&
      out_data_o.out_id_low == '0 && out_data_o.out_kind == '0 &&
      out_data_o.out_created == '0)
    else $error("Entry data shown without ok.");

  a_ok_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind != '0 |-> out_data_o.ok && out_data_o.fill != '0)
    else $error("Entry data shown from an empty table.");

endmodule

bind mru_dedup_entry_table mdet_checker u_mdet_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== verif/tb_mru_dedup_entry_table.sv =====
// Testbench for the most-recently-used entry table with duplicate removal.
// Predicts every result with its own table model and checks it field by field.
// Depends on mdet_pkg and mru_dedup_entry_table.
module tb_mru_dedup_entry_table;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  mdet_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  mdet_pkg::out_t out_data_o;

  mru_dedup_entry_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  mdet_pkg::entry_t table_q[$];
  mdet_pkg::in_t pending_q[$];
  mdet_pkg::out_t expected_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int adds = 0, removes = 0, queries = 0, reads = 0;
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;
  bit drain_wait = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int max_fill = 0;

  function automatic bit same_entry(mdet_pkg::entry_t e, mdet_pkg::in_t t);
    return e.id_high == t.id_high && e.id_low == t.id_low && e.kind == t.kind &&
           e.pos_a == t.pos_a && e.pos_b == t.pos_b && e.pos_c == t.pos_c;
  endfunction

  function automatic mdet_pkg::out_t apply_transaction(mdet_pkg::in_t t);
    mdet_pkg::out_t r;
    mdet_pkg::entry_t e;
    int hit;
    r = '0;
    hit = -1;
    if (t.action inside {mdet_pkg::ACT_ADD, mdet_pkg::ACT_CONTAINS}) begin
      foreach (table_q[i]) if (hit < 0 && same_entry(table_q[i], t)) hit = i;
    end
    case (mdet_pkg::action_e'(t.action))
      mdet_pkg::ACT_ADD: begin
        e = '{t.id_high, t.id_low, t.kind, t.pos_a, t.pos_b, t.pos_c, t.created_time};
        if (hit >= 0) table_q.delete(hit);
        else if (table_q.size() == mdet_pkg::MaxEntries) void'(table_q.pop_back());
        table_q.push_front(e);
        r.ok = 1'b1;
      end
      mdet_pkg::ACT_REMOVE: begin
        if (t.slot < table_q.size()) begin
          table_q.delete(t.slot);
          r.ok = 1'b1;
        end
      end
      mdet_pkg::ACT_CONTAINS: r.ok = hit >= 0;
      default: begin
        if (t.slot < table_q.size()) begin
          e = table_q[t.slot];
          r.ok = 1'b1;
          r.out_id_high = e.id_high;
          r.out_id_low = e.id_low;
          r.out_kind = e.kind;
          r.out_pos_a = e.pos_a;
          r.out_pos_b = e.pos_b;
          r.out_pos_c = e.pos_c;
          r.out_created = e.created;
        end
      end
    endcase
    r.fill = 7'(table_q.size());
    if (table_q.size() > max_fill) max_fill = table_q.size();
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(apply_transaction(in_data_i));
        sent <= sent + 1;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 && pending_q[0].action === 2'bxx) begin
          in_valid_i <= 1'b0;
          if (expected_q.size() == 0 && !(in_valid_i && in_ready_o)) begin
            void'(pending_q.pop_front());
            drain_wait <= 1'b1;
          end
        end else if (pending_q.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
          in_data_i <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
          if (pending_q.size() > 0 && !quiet) tx_gap <= $urandom_range(1, 19);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    mdet_pkg::out_t exp_r;
    if (out_valid_o && out_ready_i) begin
      received <= received + 1;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data_o.ok !== exp_r.ok) begin
          $error("ok: expected %0h, got %0h", exp_r.ok, out_data_o.ok); errors++;
        end
        if (out_data_o.out_id_high !== exp_r.out_id_high) begin
          $error("out_id_high: expected %0h, got %0h", exp_r.out_id_high,
                 out_data_o.out_id_high); errors++;
        end
        if (out_data_o.out_id_low !== exp_r.out_id_low) begin
          $error("out_id_low: expected %0h, got %0h", exp_r.out_id_low,
                 out_data_o.out_id_low); errors++;
        end
        if (out_data_o.out_kind !== exp_r.out_kind) begin
          $error("out_kind: expected %0h, got %0h", exp_r.out_kind, out_data_o.out_kind);
          errors++;
        end
        if (out_data_o.out_pos_a !== exp_r.out_pos_a) begin
          $error("out_pos_a: expected %0h, got %0h", exp_r.out_pos_a, out_data_o.out_pos_a);
          errors++;
        end
        if (out_data_o.out_pos_b !== exp_r.out_pos_b) begin
          $error("out_pos_b: expected %0h, got %0h", exp_r.out_pos_b, out_data_o.out_pos_b);
          errors++;
        end
        if (out_data_o.out_pos_c !== exp_r.out_pos_c) begin
          $error("out_pos_c: expected %0h, got %0h", exp_r.out_pos_c, out_data_o.out_pos_c);
          errors++;
        end
        if (out_data_o.out_created !== exp_r.out_created) begin
          $error("out_created: expected %0h, got %0h", exp_r.out_created,
                 out_data_o.out_created); errors++;
        end
        if (out_data_o.fill !== exp_r.fill) begin
          $error("fill: expected %0d, got %0d", exp_r.fill, out_data_o.fill); errors++;
        end
      end
    end
    if (hold_rx) begin
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else if (quiet || $urandom_range(0, 9) != 0) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      rx_gap <= $urandom_range(1, 19);
    end
  end

  // A small pool of keys makes duplicate adds and contains hits common.
  mdet_pkg::in_t key_pool[16];

  function automatic mdet_pkg::in_t random_entry();
    mdet_pkg::in_t t;
    t = '0;
    t.id_high = {$urandom, $urandom};
    t.id_low = {$urandom, $urandom};
    t.kind = 8'($urandom);
    t.pos_a = $urandom;
    t.pos_b = $urandom;
    t.pos_c = $urandom;
    t.created_time = $urandom;
    t.slot = 6'($urandom);
    return t;
  endfunction

  function automatic mdet_pkg::in_t make_item(mdet_pkg::action_e act, int fill_guess);
    mdet_pkg::in_t t;
    t = random_entry();
    if ($urandom_range(0, 2) != 0) begin
      t = key_pool[$urandom_range(0, 15)];
      t.created_time = $urandom;
      if ($urandom_range(0, 5) == 0) t.pos_b[$urandom_range(0, 31)] ^= 1'b1;
    end
    t.action = act;
    if (fill_guess > 0 && $urandom_range(0, 3) != 0)
      t.slot = 6'($urandom_range(0, fill_guess - 1));
    else
      t.slot = 6'($urandom);
    return t;
  endfunction

  initial begin
    mdet_pkg::in_t t;
    mdet_pkg::in_t pause_mark;
    int guess;
    pause_mark = '0;
    pause_mark.action = 2'bxx;
    foreach (key_pool[i]) key_pool[i] = random_entry();
    key_pool[0].id_high = '1; key_pool[0].id_low = '1; key_pool[0].kind = '1;
    key_pool[0].pos_a = '1; key_pool[0].pos_b = '1; key_pool[0].pos_c = '1;
    key_pool[1].id_high = '0; key_pool[1].id_low = '0; key_pool[1].kind = '0;
    key_pool[1].pos_a = '0; key_pool[1].pos_b = '0; key_pool[1].pos_c = '0;

    // Directed part: empty table, extremes, duplicates, out-of-range slots.
    t = key_pool[1]; t.action = mdet_pkg::ACT_READ; t.slot = 0; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_REMOVE; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_CONTAINS; pending_q.push_back(t);
    t = key_pool[0]; t.created_time = '1; t.action = mdet_pkg::ACT_ADD;
    pending_q.push_back(t);
    t = key_pool[1]; t.created_time = '0; t.action = mdet_pkg::ACT_ADD;
    pending_q.push_back(t);
    t = key_pool[0]; t.created_time = 32'h1234; t.action = mdet_pkg::ACT_ADD;
    pending_q.push_back(t);
    t.action = mdet_pkg::ACT_CONTAINS; pending_q.push_back(t);
    t.kind ^= 8'h01; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_READ; t.slot = 0; pending_q.push_back(t);
    t.slot = 1; pending_q.push_back(t);
    t.slot = 2; pending_q.push_back(t);
    t.slot = 6'd63; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_REMOVE; pending_q.push_back(t);
    t.slot = 0; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_READ; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_REMOVE; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_READ; pending_q.push_back(t);
    pending_q.push_back(pause_mark);

    // Fill past the limit so the oldest entry is dropped, then probe the far end.
    for (int i = 0; i < 70; i++) begin
      t = random_entry(); t.action = mdet_pkg::ACT_ADD; pending_q.push_back(t);
    end
    t.action = mdet_pkg::ACT_READ; t.slot = 6'd63; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_CONTAINS; pending_q.push_back(t);
    t = key_pool[2]; t.action = mdet_pkg::ACT_ADD; pending_q.push_back(t);
    t.action = mdet_pkg::ACT_REMOVE; t.slot = 6'd63; pending_q.push_back(t);
    pending_q.push_back(pause_mark);

    guess = mdet_pkg::MaxEntries;
    for (int i = 0; i < 610; i++) begin
      int pick;
      mdet_pkg::action_e act;
      pick = $urandom_range(0, 99);
      if (guess < 8) begin
        act = pick < 70 ? mdet_pkg::ACT_ADD : mdet_pkg::action_e'($urandom_range(1, 3));
      end else begin
        act = pick < 35 ? mdet_pkg::ACT_ADD : pick < 55 ? mdet_pkg::ACT_REMOVE :
              pick < 75 ? mdet_pkg::ACT_CONTAINS : mdet_pkg::ACT_READ;
      end
      t = make_item(act, guess);
      if (act == mdet_pkg::ACT_ADD && guess < mdet_pkg::MaxEntries) guess++;
      if (act == mdet_pkg::ACT_REMOVE && t.slot < guess && guess > 0) guess--;
      pending_q.push_back(t);
      if (i == 300) pending_q.push_back(pause_mark);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (sent >= 150);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold_rx <= 1'b0;

    wait (sent >= 550);
    quiet = 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("covered %0d transactions: %0d add, %0d remove, %0d contains, %0d read",
             received, adds, removes, queries, reads);
    $display("largest fill %0d, pause-drain reached %0d", max_fill, drain_wait);
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_mru_dedup_entry_table: done, clean");
    else
      $display("tb_mru_dedup_entry_table: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      case (mdet_pkg::action_e'(in_data_i.action))
        mdet_pkg::ACT_ADD: adds <= adds + 1;
        mdet_pkg::ACT_REMOVE: removes <= removes + 1;
        mdet_pkg::ACT_CONTAINS: queries <= queries + 1;
        default: reads <= reads + 1;
      endcase
    end
  end

  initial begin
    #20ms;
    $display("tb_mru_dedup_entry_table: done, errors");
    $finish;
  end
endmodule
